// File: sv/keyed_instance_slot_allocator_unit_assert.svh
// assertion macros for the keyed instance slot allocator
// expects clk and rst_n in the scope of the module that uses them
`ifndef KEYED_INSTANCE_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define KEYED_INSTANCE_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// condition holds at every clock edge out of reset
`define KISA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define KISA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define KISA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/kisa_pkg.sv
// shared types and constants for the keyed instance slot allocator
// no dependencies
package kisa_pkg;

    localparam int ID_W     = 16;
    localparam int KEY_W    = 17;
    localparam int RANK_W   = 15;
    localparam int HANDLE_W = 32;

    typedef enum logic
    {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // request travelling down the row of cells
    typedef struct packed
    {
        logic              valid;
        op_t               op;
        logic              done;
        status_t           status;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        logic [RANK_W-1:0] count;
    } token_t;

endpackage

// File: sv/kisa_cell.sv
// one table entry of the allocator plus the request stage that passes it
// depends on kisa_pkg
module kisa_cell
    import kisa_pkg::*;
#(
    parameter int INDEX  = 0,
    parameter int FILL_W = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [FILL_W-1:0] filled,
    input  token_t            tok_in,
    output token_t            tok_out,
    output logic              append
);

    logic [KEY_W-1:0]  key_reg,  key_next;
    logic              used_reg, used_next;
    logic [RANK_W-1:0] rank_reg, rank_next;
    token_t            tok_reg,  tok_next;
    logic              present;

    // entry exists once the fill count has passed this slot
    assign present = (FILL_W'(INDEX) < filled);

    // entry lookup and update for the passing request
    always_comb
    begin
        tok_next  = tok_in;
        key_next  = key_reg;
        used_next = used_reg;
        rank_next = rank_reg;
        append    = 1'b0;
        if (tok_in.valid && !tok_in.done)
        begin
            if (!present)
            begin
                // end of the filled part: append or give up
                tok_next.done = 1'b1;
                if (tok_in.op == OP_ADD)
                begin
                    append          = 1'b1;
                    key_next        = tok_in.key;
                    used_next       = 1'b1;
                    rank_next       = tok_in.count + RANK_W'(1);
                    tok_next.rank   = tok_in.count + RANK_W'(1);
                    tok_next.status = ST_OK;
                end
                else
                begin
                    tok_next.status = ST_NOT_FOUND;
                end
            end
            else if (key_reg == tok_in.key)
            begin
                if (tok_in.op == OP_ADD)
                begin
                    tok_next.count = tok_in.count + RANK_W'(1);
                    if (!used_reg)
                    begin
                        used_next       = 1'b1;
                        tok_next.rank   = rank_reg;
                        tok_next.done   = 1'b1;
                        tok_next.status = ST_OK;
                    end
                end
                else if (rank_reg == tok_in.rank)
                begin
                    used_next       = 1'b0;
                    tok_next.done   = 1'b1;
                    tok_next.status = ST_OK;
                end
            end
        end
    end

    // request stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    // entry contents
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg  <= key_next;
            used_reg <= used_next;
            rank_reg <= rank_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: sv/keyed_instance_slot_allocator_unit.sv
// keyed instance slot allocator: each accepted beat walks the row of TABLE_DEPTH
// entry cells, one cell per cycle while the row advances, and then the output
// register, which holds its result beat; one beat per cycle when the output
// drains, requests overlap in the row, the whole row stalls while a result
// waits
// reset clears the fill count and all request stages; entries need no clearing
`include "keyed_instance_slot_allocator_unit_assert.svh"

module keyed_instance_slot_allocator_unit
    import kisa_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] id_or_handle
    input  logic [1:0]  s_axis_tuser,   // [0] operation, [1] kind_flag
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] handle
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

    logic                  advance;
    logic [FILL_W-1:0]     filled_reg, filled_next;
    token_t                tok [0:TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] append_vec;
    logic                  grow;
    token_t                tail;
    status_t               tail_status;
    logic [HANDLE_W-1:0]   tail_handle;
    logic                  out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0]   out_handle_reg;
    status_t               out_status_reg;
    logic                  out_full, out_fail;

    // the row moves whenever the output register can take the tail
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    // incoming beat as a request
    always_comb
    begin
        tok[0]        = '0;
        tok[0].valid  = s_axis_tvalid;
        tok[0].op     = op_t'(s_axis_tuser[0]);
        tok[0].done   = 1'b0;
        tok[0].status = ST_OK;
        tok[0].count  = '0;
        if (op_t'(s_axis_tuser[0]) == OP_ADD)
        begin
            tok[0].key  = {s_axis_tuser[1], s_axis_tdata[ID_W-1:0]};
            tok[0].rank = '0;
        end
        else
        begin
            tok[0].key  = s_axis_tdata[HANDLE_W-1:RANK_W];
            tok[0].rank = s_axis_tdata[RANK_W-1:0];
        end
    end

    // row of entry cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        kisa_cell #(
            .INDEX  (i),
            .FILL_W (FILL_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .filled  (filled_reg),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .append  (append_vec[i])
        );
    end

    // fill count
    assign grow        = advance && (|append_vec);
    assign filled_next = grow ? filled_reg + FILL_W'(1) : filled_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
        end
        else
        begin
            filled_reg <= filled_next;
        end
    end

    // result of a request leaving the row
    assign tail = tok[TABLE_DEPTH];

    always_comb
    begin
        if (tail.done)
        begin
            tail_status = tail.status;
        end
        else if (tail.op == OP_ADD)
        begin
            tail_status = ST_FULL;
        end
        else
        begin
            tail_status = ST_NOT_FOUND;
        end
        if (tail.op == OP_ADD && tail_status == ST_OK)
        begin
            tail_handle = {tail.key, tail.rank};
        end
        else
        begin
            tail_handle = '0;
        end
    end

    // output register
    assign out_valid_next = advance ? tail.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_handle_reg <= tail_handle;
            out_status_reg <= tail_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_handle_reg;
    assign m_axis_tuser  = out_status_reg;

    // result beats that report a failure
    assign out_full = out_valid_reg && out_status_reg == ST_FULL;
    assign out_fail = out_valid_reg && out_status_reg != ST_OK;

    // checks on the fill count and results
    `KISA_ASSERT_ALWAYS(a_fill_bound, filled_reg <= FILL_W'(TABLE_DEPTH), "fill past depth")
    `KISA_ASSERT_ALWAYS(a_one_append, $onehot0(append_vec), "two cells append at once")
    `KISA_ASSERT_NEXT(a_fill_step, grow, filled_reg == $past(filled_reg) + FILL_W'(1), "no step")
    `KISA_ASSERT_IMPLY(a_full_real, out_full, filled_reg == FILL_W'(TABLE_DEPTH), "early full")
    `KISA_ASSERT_IMPLY(a_fail_zero, out_fail, out_handle_reg == '0, "handle on failure")

endmodule
